/* sv/rmt_pkg.sv */
package rmt_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned COUNT_W = 7;

  typedef logic signed [DATA_W-1:0] data_t;

  // per-cell control, set by the top level from the fill count
  typedef struct packed {
    logic ins;      // insertion happens this cycle
    logic occ;      // cell holds a sample (index below fill count)
    logic tail_ok;  // cell index is at or below fill count
  } cell_ctl_t;

endpackage

/* sv/rmt_cell.sv */
module rmt_cell
  import rmt_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  data_t     x,
  input  data_t     left_val,
  input  logic      left_gt,
  output data_t     val,
  output logic      gt
);

  assign gt = ctl.occ && (val > x);

  // Occupied cells holding a value <= x keep it. Every other cell up to the
  // tail takes its left neighbor when that one is larger, else the new sample.
  always_ff @(posedge clk) begin
    if (ctl.ins && ctl.tail_ok && !(ctl.occ && !gt)) begin
      val <= left_gt ? left_val : x;
    end
  end

endmodule

/* sv/running_median_tracker.sv */
// An accepted input beat is inserted, then the middle entries are selected (S_SEL)
// and added and halved (S_SUM) before out_valid rises; no new beat is taken until then;
// an unread result holds the add-and-halve step until it is taken.
// Insertion into the row of cells completes in the cycle the beat is accepted.
// Reset (rst, synchronous) empties the store and clears control state;
// no clearing pass is needed.
module running_median_tracker
  import rmt_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [DATA_W-1:0]  sample,
  input  logic                      restart,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [DATA_W-1:0]  median_value,
  output logic [COUNT_W-1:0]        stored_count,
  output logic                      overflow
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {S_IDLE, S_SEL, S_SUM} state_t;

  state_t            state;
  logic [CNT_W-1:0]  count;
  logic              dropped;
  data_t             lo_val;
  data_t             hi_val;

  logic              accept;
  logic [CNT_W-1:0]  cnt_eff;
  logic              full;
  logic              do_ins;
  logic [CNT_W-1:0]  hi_idx;
  logic [CNT_W-1:0]  lo_idx;
  data_t             lo_sel;
  data_t             hi_sel;
  logic signed [DATA_W:0] sum;
  logic signed [DATA_W:0] sum_adj;

  data_t             cell_val [CAPACITY];
  logic              cell_gt  [CAPACITY];

  assign in_ready = (state == S_IDLE) && !rst;
  assign accept   = in_valid && in_ready;
  assign cnt_eff  = restart ? '0 : count;
  assign full     = (cnt_eff >= CNT_W'(CAPACITY));
  assign do_ins   = accept && !full;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_ctl_t ctl;
    data_t     lv;
    logic      lg;

    assign ctl.ins     = do_ins;
    assign ctl.occ     = (CNT_W'(i) < cnt_eff);
    assign ctl.tail_ok = (CNT_W'(i) <= cnt_eff);

    if (i == 0) begin : g_head
      assign lv = sample;
      assign lg = 1'b0;
    end else begin : g_body
      assign lv = cell_val[i-1];
      assign lg = cell_gt[i-1];
    end

    rmt_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .x        (sample),
      .left_val (lv),
      .left_gt  (lg),
      .val      (cell_val[i]),
      .gt       (cell_gt[i])
    );
  end

  // middle entries: odd count picks the same cell twice
  assign hi_idx = count >> 1;
  assign lo_idx = count[0] ? hi_idx : hi_idx - CNT_W'(1);

  always_comb begin
    lo_sel = '0;
    hi_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (CNT_W'(i) == lo_idx) lo_sel = lo_sel | cell_val[i];
      if (CNT_W'(i) == hi_idx) hi_sel = hi_sel | cell_val[i];
    end
  end

  // halve toward zero: bias negative sums by one before the arithmetic shift
  assign sum     = {lo_val[DATA_W-1], lo_val} + {hi_val[DATA_W-1], hi_val};
  assign sum_adj = sum + {{DATA_W{1'b0}}, sum[DATA_W]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      // in S_SUM the output register is reloaded or held below
      if (out_valid && out_ready && state != S_SUM) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            count   <= full ? cnt_eff : cnt_eff + CNT_W'(1);
            dropped <= full;
            state   <= S_SEL;
          end
        end
        S_SEL: begin
          lo_val <= lo_sel;
          hi_val <= hi_sel;
          state  <= S_SUM;
        end
        S_SUM: begin
          if (!out_valid || out_ready) begin
            median_value <= DATA_W'(sum_adj >>> 1);
            stored_count <= COUNT_W'(count);
            overflow     <= dropped;
            out_valid    <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* tb/sv/running_median_tracker_tb.sv */
`timescale 1ns / 100ps

module running_median_tracker_tb
  import rmt_pkg::*;
();

  localparam int unsigned STORE_DEPTH = 64;
  localparam int unsigned PIPE_LAT = 3;
  localparam int unsigned HOLD_CYCLES = 300;

  typedef enum int {VAL_WIDE, VAL_NARROW, VAL_CORNER} value_mix_e;

  typedef struct {
    data_t              median;
    logic [COUNT_W-1:0] count;
    logic               dropped;
  } median_result_t;

  class median_scoreboard;
    data_t          held[STORE_DEPTH];
    int unsigned    fill;
    median_result_t pending_medians[$];
    int unsigned    samples, restarts, drops, results, mismatch_count;

    function void report(string what, longint exp_v, longint act_v);
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_v, act_v);
    endfunction

    // mirror of the insert: shift larger entries up, new sample after equal ones
    function void note_sample(data_t s, bit rs);
      int unsigned    pos;
      longint         mid_sum;
      median_result_t e;
      samples++;
      if (rs) begin
        fill = 0;
        restarts++;
      end
      e.dropped = (fill >= STORE_DEPTH);
      if (e.dropped) begin
        drops++;
      end else begin
        pos = fill;
        while (pos > 0 && held[pos-1] > s) begin
          held[pos] = held[pos-1];
          pos--;
        end
        held[pos] = s;
        fill++;
      end
      if (fill % 2 == 1) begin
        e.median = held[fill/2];
      end else begin
        // 64-bit sum, division truncates toward zero
        mid_sum = longint'(held[fill/2-1]) + longint'(held[fill/2]);
        e.median = data_t'(mid_sum / 2);
      end
      e.count = fill[COUNT_W-1:0];
      pending_medians.insert(pending_medians.size(), e);
    endfunction

    function void check_result(data_t m, logic [COUNT_W-1:0] c, logic o);
      median_result_t e;
      if (pending_medians.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result beat, median %0d count %0d overflow %0b",
                 $time, m, c, o);
        return;
      end
      e = pending_medians.pop_front();
      results++;
      if (m !== e.median) report("median_value", e.median, m);
      if (c !== e.count) report("stored_count", e.count, c);
      if (o !== e.dropped) report("overflow", e.dropped, o);
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  data_t              sample;
  logic               restart;
  logic               out_valid;
  logic               out_ready;
  data_t              median_value;
  logic [COUNT_W-1:0] stored_count;
  logic               overflow;

  int unsigned        src_idle_pct;
  int unsigned        snk_idle_pct;
  bit                 hold_req;
  int unsigned        hold_left;
  median_scoreboard   sb;

  running_median_tracker #(.CAPACITY(STORE_DEPTH)) uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample       (sample),
    .restart      (restart),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .median_value (median_value),
    .stored_count (stored_count),
    .overflow     (overflow)
  );

  always #5 clk = ~clk;

  // result side: check accepted beats, random stalls, one long hold-off on request
  initial begin
    out_ready = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst) begin
        out_ready <= 1'b0;
      end else begin
        if (out_valid && out_ready)
          sb.check_result(median_value, stored_count, overflow);
        if (hold_left > 0) begin
          hold_left--;
          out_ready <= 1'b0;
        end else if (hold_req) begin
          hold_req = 1'b0;
          hold_left = HOLD_CYCLES;
          out_ready <= 1'b0;
        end else begin
          out_ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
      end
    end
  end

  // returns at the edge that accepted the beat, valid still high
  task automatic send_sample(data_t s, bit rs);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= s;
    restart  <= rs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_sample(s, rs);
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (sb.pending_medians.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 7) @(posedge clk);
  endtask

  function automatic data_t pick_value(value_mix_e mix);
    case (mix)
      VAL_WIDE:   return data_t'($urandom);
      VAL_NARROW: return data_t'(int'($urandom_range(0, 15)) - 8);
      default: begin
        case ($urandom_range(0, 5))
          0:       return 32'h7FFF_FFFF;
          1:       return 32'h8000_0000;
          2:       return -1;
          3:       return 0;
          4:       return 1;
          default: return data_t'($urandom);
        endcase
      end
    endcase
  endfunction

  // runs start with restart; some runs overrun the store, a few restarts land mid-run
  task automatic feed_random_runs(int unsigned n_items, int unsigned hold_at,
                                  int unsigned pause_at);
    int unsigned sent;
    int unsigned run_len;
    int unsigned k;
    value_mix_e  mix;
    bit          rs;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 5) == 0)
        run_len = $urandom_range(60, 80);
      else
        run_len = $urandom_range(1, 16);
      mix = value_mix_e'($urandom_range(0, 2));
      for (k = 0; k < run_len && sent < n_items; k++) begin
        rs = (k == 0) || ($urandom_range(0, 24) == 0);
        send_sample(pick_value(mix), rs);
        sent++;
        if (sent == hold_at) hold_req = 1'b1;
        if (sent == pause_at) wait_results_drained();
      end
    end
  endtask

  initial begin
    clk          = 1'b0;
    rst          = 1'b1;
    in_valid     = 1'b0;
    sample       = '0;
    restart      = 1'b0;
    hold_req     = 1'b0;
    src_idle_pct = 0;
    snk_idle_pct = 0;
    sb           = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // corners: wraparound sums, truncation toward zero, equal entries, bit patterns
    send_sample(32'h7FFF_FFFF, 1'b1);
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'h8000_0000, 1'b1);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(-1, 1'b1);
    send_sample(0, 1'b0);
    send_sample(-3, 1'b1);
    send_sample(0, 1'b0);
    send_sample(32'h7FFF_FFFF, 1'b1);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(5, 1'b1);
    send_sample(5, 1'b0);
    send_sample(5, 1'b0);
    send_sample(4, 1'b0);
    send_sample(6, 1'b0);
    send_sample(32'h5555_5555, 1'b1);
    send_sample(32'hAAAA_AAAA, 1'b0);
    send_sample(-7, 1'b0);
    wait_results_drained();

    src_idle_pct = 37;
    snk_idle_pct = 66;
    feed_random_runs(220, 60, 0);
    wait_results_drained();

    src_idle_pct = 66;
    snk_idle_pct = 37;
    feed_random_runs(220, 0, 110);
    wait_results_drained();

    src_idle_pct = 0;
    snk_idle_pct = 0;
    feed_random_runs(210, 0, 0);
    wait_results_drained();

    $display("Run covered %0d samples with %0d restarts and %0d drops on a full store.",
             sb.samples, sb.restarts, sb.drops);
    $display("%0d median beats checked, %0d mismatches.", sb.results, sb.mismatch_count);
    if (sb.mismatch_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule
